// ===== design/assert_macros.svh =====
// assertion macros used by the checker file chc_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPLY(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CHK_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/chc_pkg.sv =====
// types, constants and functions for the crc16 hamming coded check block
// no dependencies
`default_nettype none

package chc_pkg;

    localparam logic        KIND_PAYLOAD = 1'b0;
    localparam logic        KIND_CODED   = 1'b1;
    localparam logic        DIR_GEN      = 1'b0;
    localparam logic        DIR_CHECK    = 1'b1;
    localparam logic        OUT_CODED    = 1'b0;
    localparam logic        OUT_VERDICT  = 1'b1;
    localparam logic [1:0]  NIB_LAST     = 2'd3;

    localparam logic [15:0] CRC_POLY = 16'h8408;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic [2:0]  SYN_D0 = 3'b111;
    localparam logic [2:0]  SYN_D1 = 3'b110;
    localparam logic [2:0]  SYN_D2 = 3'b101;
    localparam logic [2:0]  SYN_D3 = 3'b011;

    localparam logic [6:0] HCODE [16] = '{
        7'h00, 7'h71, 7'h62, 7'h13, 7'h54, 7'h25, 7'h36, 7'h47,
        7'h38, 7'h49, 7'h5a, 7'h2b, 7'h6c, 7'h1d, 7'h0e, 7'h7f
    };

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic       last_in;
    } chc_in_t;

    typedef struct packed {
        logic       out_kind;
        logic [6:0] coded_byte;
        logic       out_last;
        logic       crc_pass;
    } chc_out_t;

    // one queued result group: four coded words or a verdict
    typedef struct packed {
        logic        is_verdict;
        logic        pass;
        logic [15:0] crc;
    } chc_rec_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [2:0] ham_parity(input logic [3:0] d);
        return {d[0] ^ d[1] ^ d[2], d[0] ^ d[1] ^ d[3], d[0] ^ d[2] ^ d[3]};
    endfunction

    function automatic logic [3:0] ham_decode(input logic [6:0] v);
        logic [2:0] syn;
        logic [3:0] d;
        d   = v[3:0];
        syn = v[6:4] ^ ham_parity(v[3:0]);
        case (syn)
            SYN_D0:  d[0] = ~d[0];
            SYN_D1:  d[1] = ~d[1];
            SYN_D2:  d[2] = ~d[2];
            SYN_D3:  d[3] = ~d[3];
            default: d    = v[3:0];
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== design/chc_fifo.sv =====
// small result-group queue between the crc engine and the output serializer
// depends on chc_pkg
`default_nettype none

module chc_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    input  wire chc_pkg::chc_rec_t           push_rec,
    input  wire logic                        pop,
    output logic                             not_empty,
    output chc_pkg::chc_rec_t                rd_rec,
    output logic [$clog2(DEPTH + 1) - 1:0]   count
);
    import chc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W - 1:0] PTR_MAX = PTR_W'(DEPTH - 1);

    chc_rec_t           mem_reg [DEPTH];
    logic [PTR_W - 1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W - 1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W - 1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

    assign not_empty = (cnt_reg != '0);
    assign rd_rec    = mem_reg[rd_ptr_reg];
    assign count     = cnt_reg;

endmodule

`default_nettype wire

// ===== design/chc_engine.sv =====
// input register, crc state, hamming decode; one result group per generate frame end or check
// depends on chc_pkg
`default_nettype none

module chc_engine (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic                cfg_wdata,
    input  wire logic                in_accept,
    input  wire chc_pkg::chc_in_t    in_data,
    output logic                     pend,
    output logic                     push,
    output chc_pkg::chc_rec_t        push_rec
);
    import chc_pkg::*;

    chc_in_t     item_reg;
    logic        item_valid_reg;
    logic        dir_reg;
    logic [15:0] run_crc_reg,   run_crc_next;
    logic [15:0] final_crc_reg, final_crc_next;
    logic [1:0]  nib_cnt_reg,   nib_cnt_next;
    logic [15:0] rx_crc_reg,    rx_crc_next;

    logic [15:0] crc_upd;
    logic [3:0]  nib;
    logic [15:0] rx_full;

    always_comb
    begin
        crc_upd = crc_byte(run_crc_reg, item_reg.data_byte);
        nib     = ham_decode(item_reg.data_byte[6:0]);
        rx_full = rx_crc_reg | (16'(nib) << {nib_cnt_reg, 2'b00});

        run_crc_next   = run_crc_reg;
        final_crc_next = final_crc_reg;
        nib_cnt_next   = nib_cnt_reg;
        rx_crc_next    = rx_crc_reg;
        push           = 1'b0;
        push_rec       = '0;

        if (item_valid_reg)
        begin
            if (item_reg.kind == KIND_PAYLOAD)
            begin
                run_crc_next = crc_upd;
                if (item_reg.last_in)
                begin
                    final_crc_next = ~crc_upd;
                    run_crc_next   = CRC_INIT;
                    nib_cnt_next   = '0;
                    rx_crc_next    = '0;
                    if (dir_reg == DIR_GEN)
                    begin
                        push                = 1'b1;
                        push_rec.is_verdict = OUT_CODED;
                        push_rec.crc        = ~crc_upd;
                    end
                end
            end
            else if (dir_reg == DIR_CHECK)
            begin
                if (nib_cnt_reg == NIB_LAST)
                begin
                    push                = 1'b1;
                    push_rec.is_verdict = OUT_VERDICT;
                    push_rec.pass       = (rx_full == final_crc_reg);
                    nib_cnt_next        = '0;
                    rx_crc_next         = '0;
                end
                else
                begin
                    nib_cnt_next = nib_cnt_reg + 1'b1;
                    rx_crc_next  = rx_full;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            dir_reg        <= DIR_GEN;
            run_crc_reg    <= CRC_INIT;
            final_crc_reg  <= '0;
            nib_cnt_reg    <= '0;
            rx_crc_reg     <= '0;
        end
        else
        begin
            item_valid_reg <= in_accept;
            if (cfg_we)
            begin
                dir_reg <= cfg_wdata;
            end
            run_crc_reg   <= run_crc_next;
            final_crc_reg <= final_crc_next;
            nib_cnt_reg   <= nib_cnt_next;
            rx_crc_reg    <= rx_crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg <= in_data;
        end
    end

    assign pend = item_valid_reg;

endmodule

`default_nettype wire

// ===== design/chc_serializer.sv =====
// output register that turns a queued group into four coded words or one verdict word
// depends on chc_pkg
`default_nettype none

module chc_serializer (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                fifo_valid,
    input  wire chc_pkg::chc_rec_t   fifo_rec,
    output logic                     fifo_pop,
    input  wire logic                out_stall,
    output logic                     out_valid,
    output chc_pkg::chc_out_t        out_data
);
    import chc_pkg::*;

    chc_rec_t   hold_reg;
    logic       hold_valid_reg;
    logic [1:0] idx_reg;

    logic [3:0] nib;
    logic       fire;
    logic       done;

    always_comb
    begin
        nib      = hold_reg.crc[{idx_reg, 2'b00} +: 4];
        out_data = '0;
        if (hold_reg.is_verdict == OUT_VERDICT)
        begin
            out_data.out_kind = OUT_VERDICT;
            out_data.out_last = 1'b1;
            out_data.crc_pass = hold_reg.pass;
        end
        else
        begin
            out_data.out_kind   = OUT_CODED;
            out_data.coded_byte = HCODE[nib];
            out_data.out_last   = (idx_reg == NIB_LAST);
        end
        fire     = hold_valid_reg && !out_stall;
        done     = fire && ((hold_reg.is_verdict == OUT_VERDICT) || (idx_reg == NIB_LAST));
        fifo_pop = fifo_valid && (!hold_valid_reg || done);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            idx_reg        <= '0;
        end
        else if (fifo_pop)
        begin
            hold_valid_reg <= 1'b1;
            idx_reg        <= '0;
        end
        else if (done)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fifo_pop)
        begin
            hold_reg <= fifo_rec;
        end
    end

    assign out_valid = hold_valid_reg;

endmodule

`default_nettype wire

// ===== design/crc16_hamming_coded_check.sv =====
// path: an accepted word is held in the engine register; its result group then passes
// through the queue into the serializer output register, which shows its first result word
// throughput: one input word per cycle unless stalled; a frame end in generate mode drains
// four output words, one per cycle unless out_stall, via a FIFO_DEPTH queue setting in_stall
// reset: rst_n async active low, crc to 0xFFFF, direction generate, queue empty
`default_nettype none

module crc16_hamming_coded_check #(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic                cfg_wdata,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire chc_pkg::chc_in_t    in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output chc_pkg::chc_out_t        out_data
);
    import chc_pkg::*;

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic               in_accept;
    logic               pend;
    logic               push;
    chc_rec_t           push_rec;
    logic               pop;
    logic               not_empty;
    chc_rec_t           rd_rec;
    logic [CNT_W - 1:0] count;

    // room for the word in the engine register plus the new one
    assign in_stall  = ({1'b0, count} + (CNT_W + 1)'(pend)) >= (CNT_W + 1)'(FIFO_DEPTH);
    assign in_accept = in_valid && !in_stall;

    chc_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_accept (in_accept),
        .in_data   (in_data),
        .pend      (pend),
        .push      (push),
        .push_rec  (push_rec)
    );

    chc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_rec  (push_rec),
        .pop       (pop),
        .not_empty (not_empty),
        .rd_rec    (rd_rec),
        .count     (count)
    );

    chc_serializer u_ser (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_valid (not_empty),
        .fifo_rec   (rd_rec),
        .fifo_pop   (pop),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .out_data   (out_data)
    );

endmodule

`default_nettype wire

// ===== design/chc_checker.sv =====
// port-level assertions for crc16_hamming_coded_check, attached by bind
// depends on chc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module chc_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire chc_pkg::chc_out_t  out_data
);
    import chc_pkg::*;

    `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "output word dropped while stalled")
    `CHK_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_data), "output word changed while stalled")
    `CHK_IMPLY(a_verdict_shape, clk, rst_n, out_valid && (out_data.out_kind == OUT_VERDICT), out_data.out_last && (out_data.coded_byte == 7'h00), "verdict word malformed")
    `CHK_NEXT(a_coded_run, clk, rst_n, out_valid && !out_stall && (out_data.out_kind == OUT_CODED) && !out_data.out_last, out_valid && (out_data.out_kind == OUT_CODED) && !out_data.crc_pass, "coded word run broken")

endmodule

bind crc16_hamming_coded_check chc_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire

// ===== bench/tb_crc16_hamming_coded_check.sv =====
// testbench for crc16_hamming_coded_check: x.25 fcs over payload bytes, hamming(7,4) coded crc
// words in generate mode, corrected check and verdict in check mode
// depends on chc_pkg and the crc16_hamming_coded_check rtl

module tb_crc16_hamming_coded_check;
    timeunit 1ns;
    timeprecision 1ps;

    import chc_pkg::*;

    localparam logic [6:0] HAMMING_CODE [16] = '{
        7'h00, 7'h71, 7'h62, 7'h13, 7'h54, 7'h25, 7'h36, 7'h47,
        7'h38, 7'h49, 7'h5a, 7'h2b, 7'h6c, 7'h1d, 7'h0e, 7'h7f
    };
    localparam int TAIL_CYCLES  = 12;
    localparam int PHASE_WORDS  = 16;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     cfg_we;
    logic     cfg_wdata;
    logic     in_valid;
    logic     in_stall;
    chc_in_t  in_data;
    logic     out_valid;
    logic     out_stall;
    chc_out_t out_data;

    chc_in_t  words_to_send [$];
    chc_out_t out_words_due [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // predictor state
    logic        dir_mirror = DIR_GEN;
    logic [15:0] fcs_run    = CRC_INIT;
    logic [15:0] fcs_final  = 16'h0000;
    logic [1:0]  nib_idx    = 2'd0;
    logic [15:0] rx_fcs     = 16'h0000;

    // stimulus-side crc tracking, used to build coded tails
    logic [15:0] gen_run    = CRC_INIT;
    logic [15:0] gen_final  = 16'h0000;
    int          words_built = 0;

    int err_count     = 0;
    int words_taken   = 0;
    int frames_seen   = 0;
    int results_seen  = 0;
    int verdicts_seen = 0;
    int passes_seen   = 0;

    chc_out_t mon_want;

    crc16_hamming_coded_check dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [15:0] fcs_update(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    function automatic logic [3:0] nearest_nibble(input logic [6:0] v);
        logic [3:0] hit;
        logic       found;
        hit   = 4'd0;
        found = 1'b0;
        for (int k = 0; k < 16; k++)
        begin
            if (!found && $countones(v ^ HAMMING_CODE[k]) <= 1)
            begin
                hit   = k[3:0];
                found = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic void predict_fcs_word(input chc_in_t w);
        chc_out_t   r;
        logic [3:0] nib;
        if (w.kind == KIND_PAYLOAD)
        begin
            fcs_run = fcs_update(fcs_run, w.data_byte);
            if (w.last_in)
            begin
                fcs_final = ~fcs_run;
                fcs_run   = CRC_INIT;
                nib_idx   = 2'd0;
                rx_fcs    = 16'h0000;
                frames_seen++;
                if (dir_mirror == DIR_GEN)
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        r.out_kind   = OUT_CODED;
                        r.coded_byte = HAMMING_CODE[fcs_final[4*k +: 4]];
                        r.out_last   = (k == 3);
                        r.crc_pass   = 1'b0;
                        out_words_due.push_back(r);
                    end
                end
            end
        end
        else if (dir_mirror == DIR_CHECK)
        begin
            nib    = nearest_nibble(w.data_byte[6:0]);
            rx_fcs = rx_fcs | (16'(nib) << (4 * nib_idx));
            if (nib_idx != NIB_LAST)
                nib_idx = nib_idx + 2'd1;
            else
            begin
                r.out_kind   = OUT_VERDICT;
                r.coded_byte = 7'h00;
                r.out_last   = 1'b1;
                r.crc_pass   = (rx_fcs == fcs_final);
                out_words_due.push_back(r);
                nib_idx = 2'd0;
                rx_fcs  = 16'h0000;
            end
        end
    endfunction

    function automatic void note_mismatch(input bit have_want, input chc_out_t want,
                                          input chc_out_t got);
        err_count++;
        if (err_count <= 10)
        begin
            if (have_want)
                $display("mismatch at %0t: expected kind=%0d code=%02h last=%0d pass=%0d, got kind=%0d code=%02h last=%0d pass=%0d",
                         $realtime, want.out_kind, want.coded_byte, want.out_last, want.crc_pass,
                         got.out_kind, got.coded_byte, got.out_last, got.crc_pass);
            else
                $display("mismatch at %0t: unexpected word kind=%0d code=%02h last=%0d pass=%0d",
                         $realtime, got.out_kind, got.coded_byte, got.out_last, got.crc_pass);
        end
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_fcs_word(in_data);
                words_taken++;
            end
            if (cfg_we)
                dir_mirror = cfg_wdata;
            if (!(in_valid && in_stall))
            begin
                if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= words_to_send.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (out_data.out_kind == OUT_VERDICT)
                begin
                    verdicts_seen++;
                    if (out_data.crc_pass)
                        passes_seen++;
                end
                if (out_words_due.size() == 0)
                    note_mismatch(1'b0, out_data, out_data);
                else
                begin
                    mon_want = out_words_due.pop_front();
                    if (out_data.out_kind !== mon_want.out_kind
                        || out_data.coded_byte !== mon_want.coded_byte
                        || out_data.out_last !== mon_want.out_last
                        || out_data.crc_pass !== mon_want.crc_pass)
                        note_mismatch(1'b1, mon_want, out_data);
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic push_word(input logic k, input logic [7:0] b, input logic l);
        chc_in_t w;
        w.kind      = k;
        w.data_byte = b;
        w.last_in   = l;
        if (k == KIND_PAYLOAD)
        begin
            gen_run = fcs_update(gen_run, b);
            if (l)
            begin
                gen_final = ~gen_run;
                gen_run   = CRC_INIT;
            end
        end
        words_to_send.push_back(w);
        words_built++;
    endtask

    task automatic push_frame(input int len);
        for (int i = 0; i < len; i++)
            push_word(KIND_PAYLOAD, 8'($urandom_range(255)), i == len - 1);
    endtask

    // four coded crc words, some damaged, some with payload noise in between
    task automatic push_coded_tail();
        logic [7:0] c;
        int         b0;
        int         b1;
        for (int k = 0; k < 4; k++)
        begin
            c = {1'b0, HAMMING_CODE[gen_final[4*k +: 4]]};
            case ($urandom_range(9))
                0:
                begin
                    b0    = $urandom_range(6);
                    c[b0] = ~c[b0];
                end
                1:
                begin
                    b0    = $urandom_range(6);
                    b1    = (b0 + 1 + $urandom_range(5)) % 7;
                    c[b0] = ~c[b0];
                    c[b1] = ~c[b1];
                end
                2:       c = 8'($urandom_range(255));
                default: ;
            endcase
            if ($urandom_range(3) == 0)
                c[7] = 1'b1;
            if ($urandom_range(11) == 0)
                push_word(KIND_PAYLOAD, 8'($urandom_range(255)), 1'b0);
            push_word(KIND_CODED, c, 1'($urandom_range(1)));
        end
    endtask

    task automatic push_clean_tail(input logic [7:0] bit7_mask);
        for (int k = 0; k < 4; k++)
            push_word(KIND_CODED, {1'b0, HAMMING_CODE[gen_final[4*k +: 4]]} | bit7_mask, 1'b0);
    endtask

    task automatic settle();
        while (words_to_send.size() != 0 || in_valid || out_words_due.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    task automatic set_direction(input logic d);
        settle();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= d;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        logic dir;
        int   phase_start;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 9;
        recv_idle_pct = 85;

        // check against the cleared crc right after reset
        set_direction(DIR_CHECK);
        for (int k = 0; k < 4; k++)
            push_word(KIND_CODED, 8'h00, 1'b0);

        set_direction(DIR_GEN);
        push_word(KIND_PAYLOAD, 8'h00, 1'b1);
        push_word(KIND_PAYLOAD, 8'hff, 1'b1);
        for (int i = 0; i < 9; i++)
            push_word(KIND_PAYLOAD, 8'h31 + 8'(i), i == 8);
        push_word(KIND_CODED, 8'hff, 1'b0);
        push_word(KIND_CODED, 8'h80, 1'b1);
        push_word(KIND_PAYLOAD, 8'h5a, 1'b0);

        // switch mid frame
        set_direction(DIR_CHECK);
        push_word(KIND_PAYLOAD, 8'ha5, 1'b1);
        push_clean_tail(8'h80);
        push_frame(2);
        push_word(KIND_CODED, {1'b0, HAMMING_CODE[gen_final[3:0]]} ^ 8'h04, 1'b1);
        push_word(KIND_CODED, {1'b0, HAMMING_CODE[gen_final[7:4]]}, 1'b0);
        push_word(KIND_PAYLOAD, 8'h7e, 1'b0);
        push_word(KIND_CODED, {1'b0, HAMMING_CODE[gen_final[11:8]]} ^ 8'h41, 1'b0);
        push_word(KIND_CODED, {1'b0, HAMMING_CODE[gen_final[15:12]]}, 1'b0);
        push_word(KIND_CODED, 8'h7f, 1'b0);
        push_word(KIND_CODED, 8'h00, 1'b0);

        set_direction(DIR_GEN);
        push_word(KIND_PAYLOAD, 8'h81, 1'b1);

        for (int ph = 0; ph < 6; ph++)
        begin
            dir = (ph % 2 == 1) ? DIR_CHECK : DIR_GEN;
            set_direction(dir);
            case (ph / 2)
                0:
                begin
                    send_idle_pct = 9;
                    recv_idle_pct = 85;
                end
                1:
                begin
                    send_idle_pct = 85;
                    recv_idle_pct = 9;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            phase_start = words_built;
            while (words_built < phase_start + PHASE_WORDS)
            begin
                push_frame(($urandom_range(9) == 0) ? $urandom_range(16, 32)
                                                    : $urandom_range(1, 6));
                if (dir == DIR_CHECK)
                    push_coded_tail();
                else if ($urandom_range(5) == 0)
                    push_word(KIND_CODED, 8'($urandom_range(255)), 1'($urandom_range(1)));
            end
        end

        settle();
        $display("run covered %0d input words in %0d frames and %0d result words",
                 words_taken, frames_seen, results_seen);
        $display("check verdicts: %0d, of which %0d passed", verdicts_seen, passes_seen);
        if (err_count == 0 && out_words_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("timeout with %0d words still expected", out_words_due.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
